// ===== rtl/fpst_pkg.sv =====
// ----------------------------------------------------------------------------
// fpst_pkg: shared types and constants of the Fenwick prefix-sum table
// Field widths, stream packing, operation codes and the control bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package fpst_pkg;

  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_LEAF_WIDTH   = 7;

  localparam int MODE_W  = 2;
  localparam int IDX_W   = 10;
  localparam int INC_W   = 8;
  localparam int TGT_W   = 17;
  localparam int SUM_W   = 17;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 11;

  localparam int COUNT_RESET_VALUE = 1024;

  localparam int IN_INC_LSB = IDX_W;
  localparam int IN_TGT_LSB = IDX_W + INC_W;
  localparam int S_TDATA_W  = ((IDX_W + INC_W + TGT_W + 7) / 8) * 8;

  localparam int OUT_POS_LSB = SUM_W;
  localparam int M_TDATA_W   = ((SUM_W + POS_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 2'd0,
    MODE_QUERY   = 2'd1,
    MODE_SEARCH  = 2'd2,
    MODE_CSEARCH = 2'd3
  } mode_t;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
    logic clear;
    logic clear_restart;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic more;
    logic clear_last;
  } sts_t;

endpackage

// ===== rtl/fenwick_prefix_sum_table.sv =====
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table: Fenwick tree with add, prefix sum and search
// Each input word is one operation chosen by s_tuser; one result word is
// returned per input word.
// ----------------------------------------------------------------------------
// One operation runs at a time: the word is accepted, the walk steps
// through the visited tree nodes and the result is loaded into the output
// register. An add visits the nodes on the path to the root; a prefix
// sum query visits popcount(index + 1) nodes, index clamped to the last
// element; both searches visit one node per tree level. The walk is paced
// by the node RAM, which serves one read per cycle, one per node along the
// walk. After reset and after every write of element_count the node store
// is cleared in a pass over all MAX_ELEMENTS nodes during which s_tready
// stays low.
module fenwick_prefix_sum_table
  import fpst_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int LEAF_WIDTH   = DEF_LEAF_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [COUNT_W-1:0]   cfg_wdata,   // element_count
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,     // element_index, increment, search_value
  input  logic [MODE_W-1:0]    s_tuser,     // mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,     // prefix_sum, found_position
  output logic                 m_tuser      // none_found
);

  cmd_t             cmd;
  sts_t             sts;
  logic [SUM_W-1:0] prefix_sum;
  logic [POS_W-1:0] found_position;

  fpst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpst_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEAF_WIDTH   (LEAF_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_mode        (mode_t'(s_tuser)),
    .in_idx         (s_tdata[IDX_W-1:0]),
    .in_incr        (signed'(s_tdata[IN_INC_LSB +: INC_W])),
    .in_target      (s_tdata[IN_TGT_LSB +: TGT_W]),
    .cmd            (cmd),
    .sts            (sts),
    .prefix_sum     (prefix_sum),
    .found_position (found_position),
    .none_found     (m_tuser)
  );

  assign m_tdata = {{(M_TDATA_W - SUM_W - POS_W){1'b0}}, found_position, prefix_sum};

endmodule

// ===== rtl/fpst_ram.sv =====
// ----------------------------------------------------------------------------
// fpst_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fpst_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpst_ctrl: sequencer of the Fenwick prefix-sum table
// Runs the clearing pass, accepts one word at a time, steps the datapath
// once per tree node and hands the result to the output register.
// ----------------------------------------------------------------------------
module fpst_ctrl
  import fpst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_PUBLISH
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd               = '0;
    cmd.load          = (state == ST_IDLE) && s_tvalid;
    cmd.step          = (state == ST_RUN);
    cmd.publish       = (state == ST_PUBLISH) && out_free;
    cmd.clear         = (state == ST_CLEAR);
    cmd.clear_restart = cfg_we;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        state <= ST_CLEAR;
      end else begin
        unique case (state)
          ST_CLEAR: begin
            if (sts.clear_last) begin
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (s_tvalid) begin
              state <= sts.empty ? ST_PUBLISH : ST_RUN;
            end
          end
          ST_RUN: begin
            if (!sts.more) begin
              state <= ST_PUBLISH;
            end
          end
          ST_PUBLISH: begin
            if (out_free) begin
              state <= ST_IDLE;
            end
          end
          default: state <= ST_CLEAR;
        endcase
      end
    end
  end

endmodule

// ===== rtl/fpst_datapath.sv =====
// ----------------------------------------------------------------------------
// fpst_datapath: node store and per-node arithmetic
// Holds the element count, the node sum RAM, the walk registers of the
// current word and the result register.
// ----------------------------------------------------------------------------
module fpst_datapath
  import fpst_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int LEAF_WIDTH   = DEF_LEAF_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [COUNT_W-1:0]      cfg_wdata,
  input  mode_t                   in_mode,
  input  logic [IDX_W-1:0]        in_idx,
  input  logic signed [INC_W-1:0] in_incr,
  input  logic [TGT_W-1:0]        in_target,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  output logic [SUM_W-1:0]        prefix_sum,
  output logic [POS_W-1:0]        found_position,
  output logic                    none_found
);

  localparam int AW     = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int NI_W   = CNT_W + 1;
  localparam int NODE_W = LEAF_WIDTH + AW;
  localparam int LW     = $clog2(AW + 1);
  localparam int CMP_W  = (NODE_W > TGT_W) ? NODE_W : TGT_W;
  localparam int COUNT_RESET =
    (COUNT_RESET_VALUE < MAX_ELEMENTS) ? COUNT_RESET_VALUE : MAX_ELEMENTS;

  function automatic logic [LW-1:0] trail_zeros(input logic [NI_W-1:0] n);
    logic [LW-1:0] tz;
    tz = '0;
    for (int i = NI_W - 1; i >= 0; i--) begin
      if (n[i]) begin
        tz = LW'(i);
      end
    end
    return tz;
  endfunction

  function automatic logic [LW-1:0] top_bit(input logic [CNT_W-1:0] c);
    logic [LW-1:0] hb;
    hb = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (c[i]) begin
        hb = LW'(i);
      end
    end
    return hb;
  endfunction

  logic [CNT_W-1:0]        count;
  logic [AW-1:0]           clr_idx;
  mode_t                   mode;
  logic signed [INC_W-1:0] incr;
  logic [TGT_W-1:0]        target;
  logic [NI_W-1:0]         cur;
  logic [NI_W-1:0]         base;
  logic [LW-1:0]           lvl;
  logic [SUM_W-1:0]        acc;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [NODE_W-1:0]       ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [NODE_W-1:0]       rdata;

  logic                    idx_past;
  logic [NI_W-1:0]         first_node;
  logic [LW-1:0]           first_lvl;
  logic                    first_empty;

  logic [LW-1:0]           height;
  logic [NODE_W-1:0]       width_mask;
  logic [NODE_W-1:0]       add_val;
  logic [NI_W-1:0]         add_nxt;
  logic [NI_W-1:0]         qry_nxt;
  logic [SUM_W-1:0]        acc_new;

  logic [NODE_W-1:0]       full;
  logic                    cur_ok;
  logic                    skip;
  logic [NODE_W-1:0]       node_val;
  logic                    hit;
  logic [NI_W-1:0]         node_new;
  logic [TGT_W-1:0]        target_new;
  logic [NI_W-1:0]         srch_nxt;

  logic [NI_W-1:0]         nxt;
  logic [NI_W-1:0]         cur_next;

  // first node of the walk
  always_comb begin
    idx_past    = 32'(in_idx) >= 32'(count);
    first_lvl   = top_bit(count);
    first_empty = 1'b0;
    unique case (in_mode)
      MODE_ADD: begin
        first_node  = NI_W'(in_idx) + NI_W'(1);
        first_empty = idx_past;
      end
      MODE_QUERY: begin
        first_node = idx_past ? NI_W'(count) : NI_W'(in_idx) + NI_W'(1);
      end
      default: begin
        first_node = NI_W'(1) << first_lvl;
      end
    endcase
  end

  // add: update node, climb to parent
  assign height     = trail_zeros(cur);
  assign width_mask = (NODE_W'(1) << (LEAF_WIDTH + int'(height))) - NODE_W'(1);
  assign add_val    = (rdata + NODE_W'(incr)) & width_mask;
  assign add_nxt    = cur + (cur & (~cur + NI_W'(1)));

  // query: accumulate, drop lowest set bit
  assign acc_new = acc + SUM_W'(rdata);
  assign qry_nxt = cur & (cur - NI_W'(1));

  // search: descend one level
  always_comb begin
    full       = NODE_W'(1) << (LEAF_WIDTH + int'(lvl) - 1);
    cur_ok     = cur <= NI_W'(count);
    skip       = (mode == MODE_CSEARCH) && (rdata > full);
    node_val   = (mode == MODE_CSEARCH) ? full - rdata : rdata;
    hit        = cur_ok && !skip && (CMP_W'(target) >= CMP_W'(node_val));
    node_new   = hit ? cur : (cur & ~(NI_W'(1) << lvl));
    target_new = hit ? target - TGT_W'(node_val) : target;
    srch_nxt   = node_new | (NI_W'(1) << (lvl - LW'(1)));
  end

  always_comb begin
    unique case (mode)
      MODE_ADD: begin
        nxt      = add_nxt;
        sts.more = add_nxt <= NI_W'(count);
      end
      MODE_QUERY: begin
        nxt      = qry_nxt;
        sts.more = qry_nxt != '0;
      end
      default: begin
        nxt      = srch_nxt;
        sts.more = lvl != '0;
      end
    endcase
    sts.empty      = first_empty;
    sts.clear_last = clr_idx == AW'(MAX_ELEMENTS - 1);
  end

  always_comb begin
    priority if (cmd.load) begin
      cur_next = first_node;
    end else if (cmd.step) begin
      cur_next = nxt;
    end else begin
      cur_next = cur;
    end
  end

  assign ram_raddr = AW'(cur_next - NI_W'(1));
  assign ram_we    = cmd.clear || (cmd.step && (mode == MODE_ADD));
  assign ram_waddr = cmd.clear ? clr_idx : AW'(cur - NI_W'(1));
  assign ram_wdata = cmd.clear ? '0 : add_val;

  fpst_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= CNT_W'(COUNT_RESET);
      clr_idx <= '0;
    end else begin
      if (cfg_we) begin
        priority if (cfg_wdata == '0) begin
          count <= CNT_W'(1);
        end else if (32'(cfg_wdata) > MAX_ELEMENTS) begin
          count <= CNT_W'(MAX_ELEMENTS);
        end else begin
          count <= CNT_W'(cfg_wdata);
        end
      end
      if (cmd.clear_restart) begin
        clr_idx <= '0;
      end else if (cmd.clear) begin
        clr_idx <= clr_idx + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode   <= in_mode;
      incr   <= in_incr;
      target <= in_target;
      cur    <= first_node;
      base   <= '0;
      lvl    <= first_lvl;
      acc    <= '0;
    end else if (cmd.step) begin
      cur <= nxt;
      if (mode == MODE_QUERY) begin
        acc <= acc_new;
      end
      if (mode == MODE_SEARCH || mode == MODE_CSEARCH) begin
        base   <= node_new;
        target <= target_new;
        lvl    <= lvl - LW'(1);
      end
    end
    if (cmd.publish) begin
      prefix_sum     <= (mode == MODE_QUERY) ? acc : '0;
      found_position <= '0;
      none_found     <= 1'b0;
      if (mode == MODE_SEARCH || mode == MODE_CSEARCH) begin
        if (base == '0) begin
          none_found <= 1'b1;
        end else begin
          found_position <= POS_W'(base - NI_W'(1));
        end
      end
    end
  end

endmodule

// ===== rtl/fpst_checker.sv =====
// ----------------------------------------------------------------------------
// fpst_checker: port-level checks of the Fenwick prefix-sum table
// Watches the stream and configuration ports; bound to the top level.
// ----------------------------------------------------------------------------
module fpst_checker
  import fpst_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_we,
  input logic [COUNT_W-1:0]   cfg_wdata,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic [MODE_W-1:0]    s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tuser
);

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input accepted right after reset");

  a_clear_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("input accepted right after count write");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while one is in progress");

  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[OUT_POS_LSB +: POS_W] == '0 &&
                               m_tdata[SUM_W-1:0] == '0))
    else $error("none_found result carries nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result word changed");

endmodule

bind fenwick_prefix_sum_table fpst_checker u_checker (.*);

// ===== tb/sv/fenwick_prefix_sum_table_checker.sv =====
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table_checker: result predictor and scoreboard
// Watches the count register port and both streams of the Fenwick
// prefix-sum table. It keeps its own node store, computes the result of
// every accepted input word and compares each output word, field by field,
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table_checker
  import fpst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [COUNT_W-1:0]   cfg_wdata,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [MODE_W-1:0]    s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 m_tuser,
  output int                   outstanding,
  output int                   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_EL = DEF_MAX_ELEMENTS;
  localparam int LEAF_W = DEF_LEAF_WIDTH;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [POS_W-1:0] pos;
    logic             none;
  } fpst_result_t;

  logic [SUM_W-1:0] node_sums [MAX_EL];
  int unsigned      elem_count;
  fpst_result_t     expected_q [$];

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  task automatic reshape(input int unsigned count);
    elem_count = (count < 1) ? 1 : (count > MAX_EL) ? MAX_EL : count;
    foreach (node_sums[i]) node_sums[i] = '0;
  endtask

  function automatic int unsigned node_height(input int unsigned n);
    int unsigned h;
    h = 0;
    while (h < 31 && !n[h]) h++;
    return h;
  endfunction

  task automatic fenwick_apply(input mode_t mode, input logic [IDX_W-1:0] idx,
                               input logic [INC_W-1:0] inc, input logic [TGT_W-1:0] tgt,
                               output fpst_result_t res);
    int unsigned n, h, k, levels, node, cand, v, full, target, acc, last;
    logic [31:0] delta, mask;
    res = '0;
    case (mode)
      MODE_ADD: begin
        delta = {{(32-INC_W){inc[INC_W-1]}}, inc};
        for (n = idx + 1; n <= elem_count; n += n & (~n + 1)) begin
          mask = (32'd1 << (LEAF_W + node_height(n))) - 1;
          node_sums[n-1] = SUM_W'((32'(node_sums[n-1]) + delta) & mask);
        end
      end
      MODE_QUERY: begin
        last = (idx >= elem_count) ? elem_count - 1 : idx;
        acc = 0;
        for (n = last + 1; n != 0; n &= n - 1) acc += node_sums[n-1];
        res.sum = acc[SUM_W-1:0];
      end
      MODE_SEARCH, MODE_CSEARCH: begin
        levels = 0;
        while ((elem_count >> levels) != 0) levels++;
        node   = 0;
        target = tgt;
        for (k = levels; k > 0; k--) begin
          h    = k - 1;
          cand = node + (1 << h);
          if (cand > elem_count) continue;
          v = node_sums[cand-1];
          if (mode == MODE_CSEARCH) begin
            full = 1 << (LEAF_W + h - 1);
            if (v > full) continue;
            v = full - v;
          end
          if (target >= v) begin
            target -= v;
            node = cand;
          end
        end
        if (node == 0) begin
          res.none = 1'b1;
        end else begin
          if (node > elem_count) node = elem_count;
          res.pos = POS_W'(node - 1);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    fpst_result_t got, want;
    if (rst) begin
      reshape(COUNT_RESET_VALUE);
      expected_q.delete();
    end else begin
      if (cfg_we) reshape(cfg_wdata);
      if (m_tvalid && m_tready) begin
        got.sum  = m_tdata[SUM_W-1:0];
        got.pos  = m_tdata[OUT_POS_LSB +: POS_W];
        got.none = m_tuser;
        if (expected_q.size() == 0) begin
          report_mismatch("result word with nothing due, prefix_sum", got.sum, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.sum !== want.sum) report_mismatch("prefix_sum", got.sum, want.sum);
          if (got.pos !== want.pos) report_mismatch("found_position", got.pos, want.pos);
          if (got.none !== want.none) report_mismatch("none_found", got.none, want.none);
        end
      end
      if (s_tvalid && s_tready) begin
        fenwick_apply(mode_t'(s_tuser), s_tdata[IDX_W-1:0], s_tdata[IN_INC_LSB +: INC_W],
                      s_tdata[IN_TGT_LSB +: TGT_W], want);
        expected_q.push_back(want);
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

// ===== tb/sv/tb_fenwick_prefix_sum_table.sv =====
// ----------------------------------------------------------------------------
// tb_fenwick_prefix_sum_table: stimulus and verdict for the prefix-sum table
// Runs a directed set of edge cases, then random words over a series of
// element counts, including out-of-range counts, with random gaps on both
// streams, a long output stall, a full drain and a stretch without gaps.
// ----------------------------------------------------------------------------
module tb_fenwick_prefix_sum_table;
  import fpst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_PHASES        = 12;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int LONG_HOLD       = 400;
  localparam int SETTLE          = 32;
  localparam int TGT_MAX         = (1 << TGT_W) - 1;
  localparam int IDX_MAX         = (1 << IDX_W) - 1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [COUNT_W-1:0]   cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [MODE_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  int          words_in_flight;
  int          mismatches;
  int unsigned eff_count = COUNT_RESET_VALUE;
  int          hold_requests = 0;
  int          hold_served = 0;
  bit          quiet = 1'b0;

  int phase_counts [N_PHASES] = '{1, 0, 2, 2047, 3, 1025, 16, 100, 513, 7, 1024, 64};

  always #10 clk = ~clk;

  fenwick_prefix_sum_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  fenwick_prefix_sum_table_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .outstanding (words_in_flight),
    .fail_count  (mismatches)
  );

  initial begin : receiver
    int hold;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        m_tready <= 1'b0;
        for (hold = 0; hold < LONG_HOLD; hold++) @(posedge clk);
        hold_served++;
      end
      m_tready <= quiet || ($urandom_range(0, 99) >= 10);
    end
  end

  task automatic send_word(input mode_t mode, input logic [IDX_W-1:0] idx,
                           input logic [INC_W-1:0] inc, input logic [TGT_W-1:0] tgt);
    logic [S_TDATA_W-1:0] w;
    w = '0;
    w[IDX_W-1:0]            = idx;
    w[IN_INC_LSB +: INC_W]  = inc;
    w[IN_TGT_LSB +: TGT_W]  = tgt;
    while (!quiet && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random();
    int unsigned r, idx, tgt, hi;
    int          inc;
    mode_t       mode;
    r    = $urandom_range(0, 99);
    mode = (r < 40) ? MODE_ADD : (r < 60) ? MODE_QUERY : (r < 80) ? MODE_SEARCH : MODE_CSEARCH;
    idx  = ($urandom_range(0, 99) < 15) ? $urandom_range(0, IDX_MAX)
                                        : $urandom_range(0, eff_count - 1);
    inc  = ($urandom_range(0, 99) < 20) ? int'($urandom_range(0, 255))
                                        : int'($urandom_range(0, 128)) - 64;
    hi   = 130 * eff_count;
    if (hi > TGT_MAX) hi = TGT_MAX;
    r = $urandom_range(0, 99);
    if (r < 70)      tgt = $urandom_range(0, hi);
    else if (r < 90) tgt = $urandom_range(0, 127);
    else             tgt = $urandom_range(0, TGT_MAX);
    send_word(mode, IDX_W'(idx), INC_W'(inc), TGT_W'(tgt));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
  endtask

  task automatic write_count(input int unsigned count);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= COUNT_W'(count);
    @(posedge clk);
    cfg_we    <= 1'b0;
    eff_count = (count < 1) ? 1 : (count > DEF_MAX_ELEMENTS) ? DEF_MAX_ELEMENTS : count;
  endtask

  initial begin : stimulus
    int p, i;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_word(MODE_QUERY,   IDX_MAX, 0, 0);
    send_word(MODE_SEARCH,  0, 0, 0);
    send_word(MODE_CSEARCH, 0, 0, 0);
    send_word(MODE_ADD,     0, 64, 0);
    send_word(MODE_ADD,     0, 64, 0);
    send_word(MODE_ADD,     IDX_MAX, INC_W'(-64), 0);
    send_word(MODE_ADD,     511, INC_W'(-128), 0);
    send_word(MODE_ADD,     5, 127, 0);
    send_word(MODE_QUERY,   0, 0, 0);
    send_word(MODE_QUERY,   5, 0, 0);
    send_word(MODE_QUERY,   IDX_MAX, 0, 0);
    send_word(MODE_SEARCH,  0, 0, TGT_MAX);
    send_word(MODE_SEARCH,  0, 0, 65536);
    send_word(MODE_CSEARCH, 0, 0, TGT_MAX);
    send_word(MODE_CSEARCH, 0, 0, 64);
    send_word(MODE_ADD,     2, 100, 0);
    send_word(MODE_CSEARCH, 0, 0, 1000);
    send_word(MODE_QUERY,   512, 0, 0);
    send_word(MODE_SEARCH,  0, 0, 0);
    send_word(MODE_SEARCH,  0, 0, 200);

    for (p = 0; p < N_PHASES; p++) begin
      write_count(phase_counts[p]);
      if (p == 3) hold_requests++;
      quiet = (p == 6);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 8 && i == ITEMS_PER_PHASE / 2) drain();
        send_random();
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fpst_pkg.sv
rtl/fpst_ram.sv
rtl/fpst_ctrl.sv
rtl/fpst_datapath.sv
rtl/fenwick_prefix_sum_table.sv
rtl/fpst_checker.sv
tb/sv/fenwick_prefix_sum_table_checker.sv
tb/sv/tb_fenwick_prefix_sum_table.sv
